/* design/obb_pkg.sv */
package obb_pkg;

  // Coordinate format: signed fixed point, Q15.8 by default
  localparam int CW        = 24;
  localparam int FRAC_BITS = 8;

  // Corner differences and edges (unit cell corner adds one bit, subtract adds one)
  localparam int DW = CW + 2;
  // Full-width product and sum of two products
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  // Configuration port
  localparam int NUM_REGS = 8;
  localparam int REG_IW   = $clog2(NUM_REGS);
  localparam int APB_AW   = REG_IW + 2;
  localparam int APB_DW   = 32;

  // Register indexes
  localparam logic [REG_IW-1:0] REG_BL_X = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_BL_Y = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_BR_X = REG_IW'(2);
  localparam logic [REG_IW-1:0] REG_BR_Y = REG_IW'(3);
  localparam logic [REG_IW-1:0] REG_TR_X = REG_IW'(4);
  localparam logic [REG_IW-1:0] REG_TR_Y = REG_IW'(5);
  localparam logic [REG_IW-1:0] REG_TL_X = REG_IW'(6);
  localparam logic [REG_IW-1:0] REG_TL_Y = REG_IW'(7);

  // Operation codes
  localparam logic OP_BOX  = 1'b0;
  localparam logic OP_CELL = 1'b1;

  // Separating axis codes, in test order
  localparam logic [2:0] AXIS_REF_U = 3'd0;
  localparam logic [2:0] AXIS_REF_V = 3'd1;
  localparam logic [2:0] AXIS_BOX_U = 3'd2;
  localparam logic [2:0] AXIS_BOX_V = 3'd3;
  localparam logic [2:0] AXIS_NONE  = 3'd4;

  localparam int NUM_AXES = 4;

  typedef struct packed {
    logic                 operation;
    logic signed [CW-1:0] box_bl_x;
    logic signed [CW-1:0] box_bl_y;
    logic signed [CW-1:0] box_br_x;
    logic signed [CW-1:0] box_br_y;
    logic signed [CW-1:0] box_tr_x;
    logic signed [CW-1:0] box_tr_y;
    logic signed [CW-1:0] box_tl_x;
    logic signed [CW-1:0] box_tl_y;
  } obb_in_t;

  typedef struct packed {
    logic       overlap;
    logic [2:0] separating_axis;
  } obb_out_t;

  // One axis: edge vector and the other box's corners relative to the edge origin
  typedef struct packed {
    logic [DW-1:0]        ex;
    logic [DW-1:0]        ey;
    logic [3:0][DW-1:0]   dx;
    logic [3:0][DW-1:0]   dy;
  } obb_axis_t;

  // Exact signed product
  function automatic logic signed [PW-1:0] mul_full(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
    logic signed [PW-1:0] ae;
    logic signed [PW-1:0] be;
    ae = PW'(a);
    be = PW'(b);
    return ae * be;
  endfunction

endpackage

/* design/obb_overlap_test_2d.sv */
// Separating-axis overlap test of an input box against the configured reference box.
// Results are registered in the set-up, products, sum, compare and output stages before the out_valid strobe.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The pipeline depth is set by the per-axis multiply, sum and compare stages.
// Reset (rst_n low, synchronous) clears the reference corners and all valid bits.
module obb_overlap_test_2d
  import obb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              start,
  output logic              busy,
  input  obb_in_t           in_data,
  // result channel
  output logic              out_valid,
  output obb_out_t          out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic signed [DW-1:0] ONE_Q = DW'(1 << FRAC_BITS);

  logic signed [CW-1:0] ref_r [NUM_REGS];
  logic [REG_IW-1:0]    reg_idx;
  logic                 cfg_wr;

  logic                 accept;
  logic [3:0]           vld_r;
  obb_axis_t            axis_r   [NUM_AXES];
  obb_axis_t            axis_nxt [NUM_AXES];
  logic [NUM_AXES-1:0]  sep;
  obb_out_t             out_r;
  obb_out_t             out_nxt;
  logic                 out_valid_r;

  logic signed [DW-1:0] rx [4];
  logic signed [DW-1:0] ry [4];
  logic signed [DW-1:0] bx [4];
  logic signed [DW-1:0] by [4];

  // Configuration registers
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = APB_DW'(unsigned'(ref_r[reg_idx]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        ref_r[k] <= '0;
      end
    end else if (cfg_wr) begin
      ref_r[reg_idx] <= pwdata[CW-1:0];
    end
  end

  // Input channel: the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Corner set-up stage: expand unit cell, form edges and relative corners
  always_comb begin
    rx[0] = DW'(ref_r[REG_BL_X]);
    ry[0] = DW'(ref_r[REG_BL_Y]);
    rx[1] = DW'(ref_r[REG_BR_X]);
    ry[1] = DW'(ref_r[REG_BR_Y]);
    rx[2] = DW'(ref_r[REG_TR_X]);
    ry[2] = DW'(ref_r[REG_TR_Y]);
    rx[3] = DW'(ref_r[REG_TL_X]);
    ry[3] = DW'(ref_r[REG_TL_Y]);

    bx[0] = DW'(in_data.box_bl_x);
    by[0] = DW'(in_data.box_bl_y);
    if (in_data.operation == OP_CELL) begin
      bx[1] = bx[0] + ONE_Q;
      by[1] = by[0];
      bx[2] = bx[0] + ONE_Q;
      by[2] = by[0] + ONE_Q;
      bx[3] = bx[0];
      by[3] = by[0] + ONE_Q;
    end else begin
      bx[1] = DW'(in_data.box_br_x);
      by[1] = DW'(in_data.box_br_y);
      bx[2] = DW'(in_data.box_tr_x);
      by[2] = DW'(in_data.box_tr_y);
      bx[3] = DW'(in_data.box_tl_x);
      by[3] = DW'(in_data.box_tl_y);
    end

    axis_nxt[0].ex = rx[1] - rx[0];
    axis_nxt[0].ey = ry[1] - ry[0];
    axis_nxt[1].ex = rx[3] - rx[0];
    axis_nxt[1].ey = ry[3] - ry[0];
    axis_nxt[2].ex = bx[1] - bx[0];
    axis_nxt[2].ey = by[1] - by[0];
    axis_nxt[3].ex = bx[3] - bx[0];
    axis_nxt[3].ey = by[3] - by[0];
    for (int j = 0; j < 4; j++) begin
      axis_nxt[0].dx[j] = bx[j] - rx[0];
      axis_nxt[0].dy[j] = by[j] - ry[0];
      axis_nxt[1].dx[j] = bx[j] - rx[0];
      axis_nxt[1].dy[j] = by[j] - ry[0];
      axis_nxt[2].dx[j] = rx[j] - bx[0];
      axis_nxt[2].dy[j] = ry[j] - by[0];
      axis_nxt[3].dx[j] = rx[j] - bx[0];
      axis_nxt[3].dy[j] = ry[j] - by[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_r[a] <= axis_nxt[a];
    end
  end

  // Per-axis projection pipelines
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    obb_axis u_axis (
      .clk    (clk),
      .axis_i (axis_r[a]),
      .sep_o  (sep[a])
    );
  end

  // Pick the first separating axis in test order
  always_comb begin
    out_nxt.overlap         = 1'b0;
    out_nxt.separating_axis = AXIS_NONE;
    if (sep[0]) begin
      out_nxt.separating_axis = AXIS_REF_U;
    end else if (sep[1]) begin
      out_nxt.separating_axis = AXIS_REF_V;
    end else if (sep[2]) begin
      out_nxt.separating_axis = AXIS_BOX_U;
    end else if (sep[3]) begin
      out_nxt.separating_axis = AXIS_BOX_V;
    end else begin
      out_nxt.overlap = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[2:0], accept};
      out_valid_r <= vld_r[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/obb_axis.sv */
module obb_axis
  import obb_pkg::*;
(
  input  logic      clk,
  input  obb_axis_t axis_i,
  output logic      sep_o
);

  logic signed [PW-1:0] px_r  [4];
  logic signed [PW-1:0] py_r  [4];
  logic signed [PW-1:0] exx_r;
  logic signed [PW-1:0] eyy_r;
  logic signed [SW-1:0] t_r   [4];
  logic signed [SW-1:0] len2_r;
  logic                 sep_r;
  logic                 sep_nxt;
  logic [3:0]           above;
  logic [3:0]           below;

  // Products stage: projection terms and squared edge length
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      px_r[j] <= mul_full($signed(axis_i.dx[j]), $signed(axis_i.ex));
      py_r[j] <= mul_full($signed(axis_i.dy[j]), $signed(axis_i.ey));
    end
    exx_r <= mul_full($signed(axis_i.ex), $signed(axis_i.ex));
    eyy_r <= mul_full($signed(axis_i.ey), $signed(axis_i.ey));
  end

  // Sum stage: dot products
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      t_r[j] <= SW'(px_r[j]) + SW'(py_r[j]);
    end
    len2_r <= SW'(exx_r) + SW'(eyy_r);
  end

  // Compare stage: all projections beyond the edge, or all behind its origin
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      above[j] = t_r[j] > len2_r;
      below[j] = t_r[j] < SW'(0);
    end
    sep_nxt = (&above) | (&below);
  end

  always_ff @(posedge clk) begin
    sep_r <= sep_nxt;
  end

  assign sep_o = sep_r;

endmodule

/* design/obb_chk.sv */
module obb_chk
  import obb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  logic     out_valid,
  input  obb_out_t out_data
);

  // Every accepted transfer yields a result on out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted item produced no result");

  // No result without an earlier accepted transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without matching input");

  // Overlap flag agrees with the axis code
  a_overlap_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.overlap == (out_data.separating_axis == AXIS_NONE)))
    else $error("overlap flag disagrees with separating axis");

  // Axis code stays within the defined set
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.separating_axis == AXIS_REF_U ||
                   out_data.separating_axis == AXIS_REF_V ||
                   out_data.separating_axis == AXIS_BOX_U ||
                   out_data.separating_axis == AXIS_BOX_V ||
                   out_data.separating_axis == AXIS_NONE))
    else $error("separating axis code out of range");

endmodule

bind obb_overlap_test_2d obb_chk u_obb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
